FILE: hdl/ralu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ralu_pkg
// shared types and constants for the rational arithmetic unit
// ----------------------------------------------------------------------------
package ralu_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;

  // operation codes
  localparam logic [1:0] FN_ADD = 2'd0;
  localparam logic [1:0] FN_SUB = 2'd1;
  localparam logic [1:0] FN_MUL = 2'd2;
  localparam logic [1:0] FN_DIV = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [1:0] ST_ZERO_DEN = 2'd2;

  // which cross product the shared multiplier forms
  typedef enum logic [1:0] {
    MSEL_P0 = 2'd0,
    MSEL_P1 = 2'd1,
    MSEL_P2 = 2'd2
  } mul_sel_t;

  // which magnitude goes into the divider
  typedef enum logic {
    DSEL_NUM = 1'b0,
    DSEL_DEN = 1'b1
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_COMBINE,
    S_ZCHK,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic     accept;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     combine;
    logic     gcd_step;
    logic     div_load;
    div_sel_t div_sel;
    logic     div_step;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic zero;
    logic gcd_done;
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

FILE: hdl/ralu_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ralu_ctrl
// sequencer: multiply, combine, binary gcd, two divisions, output
// ----------------------------------------------------------------------------
module ralu_ctrl
  import ralu_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  wire  logic out_stall,
  input  wire  sts_t sts,
  output cmd_t       cmd
);

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel = MSEL_P0;
    cmd.div_sel = DSEL_NUM;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = sts.err ? S_FINISH : S_MUL0;
      end
      S_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_P0;
        state_next  = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_P1;
        state_next  = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_P2;
        state_next  = S_COMBINE;
      end
      S_COMBINE: begin
        cmd.combine = 1'b1;
        state_next  = S_ZCHK;
      end
      S_ZCHK: begin
        state_next = sts.zero ? S_FINISH : S_GCD;
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          cmd.div_load = 1'b1;
          cmd.div_sel  = DSEL_NUM;
          state_next   = S_DIVN;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIVN: begin
        if (sts.div_done) begin
          cmd.div_load = 1'b1;
          cmd.div_sel  = DSEL_DEN;
          state_next   = S_DIVD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DIVD: begin
        if (sts.div_done) begin
          state_next = S_FINISH;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/ralu_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ralu_dp
// operand store, shared multiplier, binary gcd and restoring divider
// ----------------------------------------------------------------------------
module ralu_dp
  import ralu_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  wire  logic                         clk,
  input  wire  logic                         rst,
  input  wire  cmd_t                         cmd,
  output sts_t                               sts,
  input  wire  logic [1:0]                   func,
  input  wire  logic signed [OPERAND_WIDTH-1:0] num_a,
  input  wire  logic signed [OPERAND_WIDTH-1:0] den_a,
  input  wire  logic signed [OPERAND_WIDTH-1:0] num_b,
  input  wire  logic signed [OPERAND_WIDTH-1:0] den_b,
  output logic signed [2*OPERAND_WIDTH:0]     num_out,
  output logic [2*OPERAND_WIDTH-2:0]          den_out,
  output logic [1:0]                          status
);

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W;
  localparam int NW = 2 * W + 1;
  localparam int MW = 2 * W;
  localparam int DW = 2 * W - 1;
  localparam int CW = $clog2(MW + 1);

  logic [1:0]           op;
  logic signed [W-1:0]  na, da, nb, db;
  logic [1:0]           st;
  logic signed [PW-1:0] p0, p1, p2;
  logic signed [W-1:0]  mul_x, mul_y;
  logic signed [PW-1:0] prod;
  logic signed [NW-1:0] rn;
  logic [MW-1:0]        mn_c, md_c;
  logic [MW-1:0]        mn, md;
  logic                 neg, zero;
  logic [MW-1:0]        ga, gb, g;
  logic [CW-1:0]        k;
  logic [MW-1:0]        dvd, dvsr, quo, rem, num_q;
  logic [MW:0]          rem_sh;
  logic                 fits;
  logic [CW-1:0]        cnt;
  logic [NW-1:0]        num_ext;

  always_comb begin
    mul_x = na;
    mul_y = db;
    case (cmd.mul_sel)
      MSEL_P0: begin
        mul_x = na;
        mul_y = (op == FN_MUL) ? nb : db;
      end
      MSEL_P1: begin
        mul_x = nb;
        mul_y = da;
      end
      default: begin
        mul_x = da;
        mul_y = (op == FN_DIV) ? nb : db;
      end
    endcase
  end

  assign prod = mul_x * mul_y;

  // combine the cross products into a signed numerator and take magnitudes
  always_comb begin
    case (op)
      FN_ADD:  rn = {p0[PW-1], p0} + {p1[PW-1], p1};
      FN_SUB:  rn = {p0[PW-1], p0} - {p1[PW-1], p1};
      default: rn = {p0[PW-1], p0};
    endcase
    mn_c = rn[NW-1] ? MW'(-rn) : MW'(rn);
    md_c = p2[PW-1] ? MW'(-p2) : MW'(p2);
  end

  assign g      = MW'((ga | gb) << k);
  assign rem_sh = {rem, dvd[MW-1]};
  assign fits   = (rem_sh >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op <= func;
      na <= num_a;
      da <= den_a;
      nb <= num_b;
      db <= den_b;
      if (den_a == '0 || den_b == '0) begin
        st <= ST_ZERO_DEN;
      end else if (func == FN_DIV && num_b == '0) begin
        st <= ST_DIV_ZERO;
      end else begin
        st <= ST_OK;
      end
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MSEL_P0: p0 <= prod;
        MSEL_P1: p1 <= prod;
        default: p2 <= prod;
      endcase
    end
    if (cmd.combine) begin
      mn   <= mn_c;
      md   <= md_c;
      neg  <= rn[NW-1] ^ p2[PW-1];
      zero <= (mn_c == '0);
      ga   <= mn_c;
      gb   <= md_c;
      k    <= '0;
    end else if (cmd.gcd_step) begin
      if (!ga[0] && !gb[0]) begin
        ga <= ga >> 1;
        gb <= gb >> 1;
        k  <= k + CW'(1);
      end else if (!ga[0]) begin
        ga <= ga >> 1;
      end else if (!gb[0]) begin
        gb <= gb >> 1;
      end else if (ga >= gb) begin
        ga <= (ga - gb) >> 1;
      end else begin
        gb <= (gb - ga) >> 1;
      end
    end
    if (rst) begin
      cnt <= '0;
    end else if (cmd.div_load) begin
      dvd  <= (cmd.div_sel == DSEL_DEN) ? md : mn;
      dvsr <= g;
      rem  <= '0;
      quo  <= '0;
      cnt  <= '0;
      if (cmd.div_sel == DSEL_DEN) begin
        num_q <= quo;
      end
    end else if (cmd.div_step) begin
      rem <= fits ? MW'(rem_sh - {1'b0, dvsr}) : MW'(rem_sh);
      quo <= {quo[MW-2:0], fits};
      dvd <= dvd << 1;
      cnt <= cnt + CW'(1);
    end
    if (cmd.out_load) begin
      status <= st;
      if (st != ST_OK) begin
        num_out <= '0;
        den_out <= '0;
      end else if (zero) begin
        num_out <= '0;
        den_out <= DW'(1);
      end else begin
        num_out <= neg ? -num_ext : num_ext;
        den_out <= quo[DW-1:0];
      end
    end
  end

  assign num_ext = {1'b0, num_q};

  assign sts.err      = (st != ST_OK);
  assign sts.zero     = zero;
  assign sts.gcd_done = (ga == '0) || (gb == '0);
  assign sts.div_done = (cnt == CW'(MW));

endmodule
`default_nettype wire

FILE: hdl/rational_alu_reduce_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rational_alu_reduce_top
// exact add, subtract, multiply and divide of two signed fractions
// ----------------------------------------------------------------------------
// one item carries func and two fractions num_a/den_a and num_b/den_b; one
// result item follows with the fraction reduced to lowest terms, the sign on
// num_out and den_out positive, 0/1 for a zero result. a zero input
// denominator gives status 2, a divide by a zero fraction gives status 1,
// both with zero fields. the block works on one item at a time: a valid item
// passes through the cross-product multiplies, the combine, the binary gcd
// loop and two restoring divisions in the bit per cycle divider; error items
// skip all of these, and zero results skip the gcd and the divisions. a
// finished result sits in the output register until taken, and the next
// item is accepted as soon as the result has been moved there.
module rational_alu_reduce_top
  import ralu_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  wire  logic                            clk,
  input  wire  logic                            rst,
  // input channel
  input  wire  logic                            in_valid,
  output logic                                  in_stall,
  input  wire  logic [1:0]                      func,
  input  wire  logic signed [OPERAND_WIDTH-1:0] num_a,
  input  wire  logic signed [OPERAND_WIDTH-1:0] den_a,
  input  wire  logic signed [OPERAND_WIDTH-1:0] num_b,
  input  wire  logic signed [OPERAND_WIDTH-1:0] den_b,
  // result channel
  output logic                                  out_valid,
  input  wire  logic                            out_stall,
  output logic signed [2*OPERAND_WIDTH:0]       num_out,
  output logic [2*OPERAND_WIDTH-2:0]            den_out,
  output logic [1:0]                            status
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  ralu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ralu_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .func    (func),
    .num_a   (num_a),
    .den_a   (den_a),
    .num_b   (num_b),
    .den_b   (den_b),
    .num_out (num_out),
    .den_out (den_out),
    .status  (status)
  );

endmodule
`default_nettype wire

FILE: hdl/ralu_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ralu_checker
// port level checks on the rational arithmetic unit
// ----------------------------------------------------------------------------
module ralu_checker
  import ralu_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic signed [2*OPERAND_WIDTH:0] num_out,
  input wire logic [2*OPERAND_WIDTH-2:0]    den_out,
  input wire logic [1:0]                    status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> num_out == '0 && den_out == '0)
    else $error("error result with nonzero fields");

  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> den_out != '0)
    else $error("zero denominator on good result");

  a_zero_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK && num_out == '0 |-> den_out == 1)
    else $error("zero result not 0/1");

endmodule

bind rational_alu_reduce_top ralu_checker #(
  .OPERAND_WIDTH (OPERAND_WIDTH)
) u_ralu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .num_out   (num_out),
  .den_out   (den_out),
  .status    (status)
);
`default_nettype wire

FILE: test/rational_alu_reduce_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rational_alu_reduce_top_tb
// self-checking bench for the rational arithmetic unit
// ----------------------------------------------------------------------------
// directed fractions cover the operand extremes, all four operations, zero
// denominators, divide by a zero fraction, both errors together and zero
// results. random fractions follow, drawn mostly from small and mid ranges
// with some full-range values. an in-line predictor forms the exact result
// in 64-bit arithmetic and reduces it. results are compared field by field,
// in order, while both sides idle at random.
// ----------------------------------------------------------------------------
module rational_alu_reduce_top_tb
  import ralu_pkg::*;
;

  localparam int W = OPERAND_WIDTH_DEF;
  localparam int NW = 2 * W + 1;
  localparam int DW = 2 * W - 1;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [NW-1:0] num;
    logic [DW-1:0] den;
    logic [1:0]    st;
  } fraction_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] func = FN_ADD;
  logic signed [W-1:0] num_a = '0, den_a = '0, num_b = '0, den_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [NW-1:0] num_out;
  logic [DW-1:0] den_out;
  logic [1:0] status;

  // predicted fractions still owed by the block
  fraction_res_t owed_fractions[$];
  int mismatches = 0;
  longint cycles = 0;
  bit sending_done = 1'b0;

  rational_alu_reduce_top #(.OPERAND_WIDTH(W)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .num_a(num_a), .den_a(den_a), .num_b(num_b), .den_b(den_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .num_out(num_out), .den_out(den_out), .status(status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // exact cross product, then reduction by the common divisor of magnitudes
  function automatic fraction_res_t reduce_fraction(logic [1:0] op,
      logic signed [W-1:0] na, logic signed [W-1:0] da,
      logic signed [W-1:0] nb, logic signed [W-1:0] db);
    fraction_res_t r;
    longint rn, rd, mn, md, a, b, t;
    r = '0;
    if (da == 0 || db == 0) begin
      r.st = ST_ZERO_DEN;
      return r;
    end
    if (op == FN_DIV && nb == 0) begin
      r.st = ST_DIV_ZERO;
      return r;
    end
    case (op)
      FN_ADD: begin
        rn = longint'(na) * db + longint'(nb) * da;
        rd = longint'(da) * db;
      end
      FN_SUB: begin
        rn = longint'(na) * db - longint'(nb) * da;
        rd = longint'(da) * db;
      end
      FN_MUL: begin
        rn = longint'(na) * nb;
        rd = longint'(da) * db;
      end
      default: begin
        rn = longint'(na) * db;
        rd = longint'(da) * nb;
      end
    endcase
    r.st = ST_OK;
    if (rn == 0) begin
      r.den = DW'(1);
      return r;
    end
    mn = rn < 0 ? -rn : rn;
    md = rd < 0 ? -rd : rd;
    a = mn;
    b = md;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    mn = mn / a;
    md = md / a;
    r.num = ((rn < 0) != (rd < 0)) ? NW'(-mn) : NW'(mn);
    r.den = DW'(md);
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 200);
  endfunction

  // operand drawn from a mix of small, mid and full ranges plus extremes
  function automatic logic signed [W-1:0] pick_operand();
    int p;
    p = $urandom_range(0, 99);
    if (p < 35) return W'($signed($urandom_range(0, 40)) - 20);
    if (p < 60) return W'($signed($urandom_range(0, 2000)) - 1000);
    if (p < 70) begin
      case ($urandom_range(0, 3))
        0: return {1'b1, {(W-1){1'b0}}};
        1: return {1'b0, {(W-1){1'b1}}};
        2: return '1;
        default: return W'(1);
      endcase
    end
    return W'($urandom);
  endfunction

  task automatic send_fraction(logic [1:0] op, logic signed [W-1:0] na,
      logic signed [W-1:0] da, logic signed [W-1:0] nb, logic signed [W-1:0] db);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= op;
    num_a <= na;
    den_a <= da;
    num_b <= nb;
    den_b <= db;
    owed_fractions.push_back(reduce_fraction(op, na, da, nb, db));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // operand extremes under every operation, and each error case
  task automatic test_directed();
    logic signed [W-1:0] mx, mn;
    mx = {1'b0, {(W-1){1'b1}}};
    mn = {1'b1, {(W-1){1'b0}}};
    send_fraction(FN_ADD, mx, mx, mx, mn);
    send_fraction(FN_ADD, mn, 1, mn, 1);
    send_fraction(FN_SUB, mn, 1, mx, 1);
    send_fraction(FN_SUB, 3, 4, 3, 4);       // zero result
    send_fraction(FN_MUL, mn, 1, mn, 1);
    send_fraction(FN_MUL, mn, mx, mx, mn);
    send_fraction(FN_MUL, 0, -5, 7, 3);      // zero result
    send_fraction(FN_DIV, mn, 1, 1, mn);
    send_fraction(FN_DIV, 1, mn, mn, 1);
    send_fraction(FN_DIV, -6, 4, 9, -2);
    send_fraction(FN_DIV, 5, 7, 0, 3);       // divide by zero fraction
    send_fraction(FN_DIV, 0, 7, 3, 2);
    send_fraction(FN_ADD, 1, 0, 2, 3);       // zero denominator
    send_fraction(FN_SUB, 1, 2, 2, 0);
    send_fraction(FN_MUL, -1, 0, -1, 0);
    send_fraction(FN_DIV, 1, 0, 0, 3);       // both errors, zero den wins
    send_fraction(FN_ADD, -1, -1, -1, -1);
    send_fraction(FN_ADD, 1, -3, 1, 6);
  endtask

  task automatic test_random(int count);
    logic signed [W-1:0] da, db;
    repeat (count) begin
      da = pick_operand();
      db = pick_operand();
      // keep zero denominators occasional
      if (da == 0 && $urandom_range(0, 3) != 0) da = 1;
      if (db == 0 && $urandom_range(0, 3) != 0) db = -1;
      send_fraction(2'($urandom), pick_operand(), da, pick_operand(), db);
    end
  endtask

  // receiver stalls at random, with quiet stretches
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (cycles % 4000 < 600) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 30) ? 1'b1 : 1'b0;
  end

  // result checker
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      if (owed_fractions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %0d/%0d st %0d",
          num_out, den_out, status);
      end else begin
        fraction_res_t e;
        e = owed_fractions.pop_front();
        if (e.num !== num_out || e.den !== den_out || e.st !== status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%0d st %0d, got %0d/%0d st %0d",
              $signed(e.num), e.den, e.st, num_out, den_out, status);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(1340);
    in_valid <= 1'b0;
    while (owed_fractions.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
